@@ hdl/isofb_pkg.sv @@
// shared types, constants and helper functions for the iso14443a frame builder
// no dependencies; imported by every module of the block
package isofb_pkg;

    localparam int MAX_FRAME   = 256;
    localparam int FB_W        = $clog2(MAX_FRAME + 1);
    localparam int TOTAL_W     = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QL_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_PRESET = 16'h6363;
    localparam logic [3:0]  BYTE_BITS  = 4'd8;
    localparam logic [3:0]  ONE_BIT    = 4'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       crc_en;
        logic       par_en;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [3:0]         out_bits;
        logic               frame_end;
        logic [TOTAL_W-1:0] total_bits;
        logic               overflow;
    } rsp_t;

    // one byte operation handed from the front to the packer
    typedef struct packed {
        logic [7:0]         data;
        logic               put;
        logic               parity;
        logic               last;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        F_PAYLOAD,
        F_CRC_LO,
        F_CRC_HI
    } front_state_t;

    typedef enum logic [1:0] {
        B_DATA,
        B_PARITY,
        B_FLUSH
    } back_state_t;

    function automatic logic [15:0] crc_a_update(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] b;
        b = data ^ crc[7:0];
        b = b ^ {b[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {b, 8'h00} ^ {5'b00000, b, 3'b000} ^ {12'h000, b[7:4]};
    endfunction

    function automatic logic odd_parity(input logic [7:0] data);
        return ~(^data);
    endfunction

    // bytes times 8, or times 9 with parity
    function automatic logic [TOTAL_W-1:0] frame_total(input logic [FB_W-1:0] n, input logic par);
        logic [TOTAL_W-1:0] w;
        w = TOTAL_W'(n);
        return (w << 3) + (par ? w : '0);
    endfunction

endpackage

@@ hdl/isofb_queue.sv @@
// short op queue between the front and the packer
// depends on isofb_pkg (op_t, q_status_t, QUEUE_DEPTH)
module isofb_queue import isofb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  op_t       wr_op,
    input  logic      rd,
    output op_t       rd_op,
    output q_status_t status
);

    op_t             mem_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QL_W-1:0] level_reg, level_next;
    logic            do_wr, do_rd;

    assign status.full  = (level_reg == QL_W'(QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_op        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

@@ hdl/isofb_front.sv @@
// front end: takes payload bytes, keeps crc, byte count and overflow,
// queues byte operations for the packer; depends on isofb_pkg
module isofb_front import isofb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req_data,
    input  logic      req_valid,
    output logic      req_stall,
    output op_t       op,
    output logic      op_push,
    input  q_status_t q_status
);

    front_state_t    state_reg, state_next;
    logic            in_frame_reg, in_frame_next;
    logic            crc_on_reg, crc_on_next;
    logic            par_on_reg, par_on_next;
    logic [15:0]     crc_reg, crc_next;
    logic [FB_W-1:0] fbytes_reg, fbytes_next;
    logic            ovf_reg, ovf_next;

    logic            start, accept, take;
    logic            crc_on, par_on, ovf_eff;
    logic [15:0]     crc_eff;
    logic [FB_W-1:0] fb_eff, limit, fb_after;

    // first byte of a frame samples the flags and restarts the frame state
    assign start    = !in_frame_reg;
    assign crc_on   = start ? req_data.crc_en : crc_on_reg;
    assign par_on   = start ? req_data.par_en : par_on_reg;
    assign crc_eff  = start ? CRC_PRESET : crc_reg;
    assign fb_eff   = start ? '0 : fbytes_reg;
    assign ovf_eff  = start ? 1'b0 : ovf_reg;
    assign limit    = crc_on ? FB_W'(MAX_FRAME - 2) : FB_W'(MAX_FRAME);
    assign take     = (fb_eff < limit);
    assign fb_after = fb_eff + FB_W'(take);

    assign req_stall = (state_reg != F_PAYLOAD) || q_status.full;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_PAYLOAD:
            begin
                if (accept && req_data.last_byte && crc_on)
                begin
                    state_next = F_CRC_LO;
                end
            end
            F_CRC_LO:
            begin
                if (!q_status.full)
                begin
                    state_next = F_CRC_HI;
                end
            end
            F_CRC_HI:
            begin
                if (!q_status.full)
                begin
                    state_next = F_PAYLOAD;
                end
            end
            default:
            begin
                state_next = F_PAYLOAD;
            end
        endcase
    end

    always_comb
    begin
        op            = '0;
        op_push       = 1'b0;
        in_frame_next = in_frame_reg;
        crc_on_next   = crc_on_reg;
        par_on_next   = par_on_reg;
        crc_next      = crc_reg;
        fbytes_next   = fbytes_reg;
        ovf_next      = ovf_reg;
        unique case (state_reg)
            F_PAYLOAD:
            begin
                op.data     = req_data.data_byte;
                op.put      = take;
                op.parity   = par_on;
                op.last     = req_data.last_byte && !crc_on;
                op.total    = frame_total(fb_after, par_on);
                op.overflow = ovf_eff || !take;
                // a dropped byte needs no op unless it closes a frame without crc
                op_push     = accept && (take || op.last);
                if (accept)
                begin
                    in_frame_next = !req_data.last_byte;
                    crc_on_next   = crc_on;
                    par_on_next   = par_on;
                    crc_next      = take ? crc_a_update(crc_eff, req_data.data_byte) : crc_eff;
                    fbytes_next   = fb_after;
                    ovf_next      = ovf_eff || !take;
                end
            end
            F_CRC_LO:
            begin
                op.data     = crc_reg[7:0];
                op.put      = 1'b1;
                op.parity   = par_on_reg;
                op.last     = 1'b0;
                op.total    = '0;
                op.overflow = 1'b0;
                op_push     = !q_status.full;
                if (!q_status.full)
                begin
                    fbytes_next = fbytes_reg + 1'b1;
                end
            end
            F_CRC_HI:
            begin
                op.data     = crc_reg[15:8];
                op.put      = 1'b1;
                op.parity   = par_on_reg;
                op.last     = 1'b1;
                op.total    = frame_total(fbytes_reg + 1'b1, par_on_reg);
                op.overflow = ovf_reg;
                op_push     = !q_status.full;
                if (!q_status.full)
                begin
                    fbytes_next = fbytes_reg + 1'b1;
                end
            end
            default:
            begin
                op_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_PAYLOAD;
            in_frame_reg <= 1'b0;
            crc_on_reg   <= 1'b0;
            par_on_reg   <= 1'b0;
            crc_reg      <= CRC_PRESET;
            fbytes_reg   <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_frame_reg <= in_frame_next;
            crc_on_reg   <= crc_on_next;
            par_on_reg   <= par_on_next;
            crc_reg      <= crc_next;
            fbytes_reg   <= fbytes_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

@@ hdl/isofb_back.sv @@
// back end: bit packer, appends byte and parity bits LSB first and emits
// output bytes through an output register; depends on isofb_pkg
module isofb_back import isofb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  op_t       op,
    input  q_status_t q_status,
    output logic      op_pop,
    output rsp_t      rsp_data,
    output logic      rsp_valid,
    input  logic      rsp_stall
);

    back_state_t state_reg, state_next;
    logic [15:0] accum_reg, accum_next;
    logic [3:0]  count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg, out_next;

    logic        have, out_free, need_emit, can_push, flush_go, flush_end;
    logic [15:0] base_acc, shifted;
    logic [3:0]  base_cnt, flush_bits;
    logic [7:0]  push_val, flush_mask;
    logic [3:0]  push_k;

    assign have      = !q_status.empty;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign need_emit = count_reg[3];
    assign can_push  = have && (!need_emit || out_free);
    assign flush_go  = have && out_free;
    assign flush_end = (count_reg <= BYTE_BITS);
    assign shifted   = {8'h00, accum_reg[15:8]};
    assign base_acc  = need_emit ? shifted : accum_reg;
    // after an emit fewer than eight bits remain
    assign base_cnt  = {1'b0, count_reg[2:0]};
    assign push_val  = (state_reg == B_PARITY) ? {7'b0, odd_parity(op.data)} : op.data;
    assign push_k    = (state_reg == B_PARITY) ? ONE_BIT : BYTE_BITS;
    assign flush_bits = flush_end ? count_reg : BYTE_BITS;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            flush_mask[i] = (4'(i) < flush_bits);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_DATA:
            begin
                if (have && !op.put)
                begin
                    state_next = B_FLUSH;
                end
                else if (can_push)
                begin
                    if (op.parity)
                    begin
                        state_next = B_PARITY;
                    end
                    else if (op.last)
                    begin
                        state_next = B_FLUSH;
                    end
                end
            end
            B_PARITY:
            begin
                if (can_push)
                begin
                    state_next = op.last ? B_FLUSH : B_DATA;
                end
            end
            B_FLUSH:
            begin
                if (flush_go && flush_end)
                begin
                    state_next = B_DATA;
                end
            end
            default:
            begin
                state_next = B_DATA;
            end
        endcase
    end

    always_comb
    begin
        logic emit;
        rsp_t beat;
        emit       = 1'b0;
        beat       = '0;
        op_pop     = 1'b0;
        accum_next = accum_reg;
        count_next = count_reg;
        unique case (state_reg)
            B_DATA, B_PARITY:
            begin
                if (can_push && (op.put || state_reg == B_PARITY))
                begin
                    emit          = need_emit;
                    beat.out_byte = accum_reg[7:0];
                    beat.out_bits = BYTE_BITS;
                    accum_next    = base_acc | (16'(push_val) << base_cnt[2:0]);
                    count_next    = base_cnt + push_k;
                    if (state_reg == B_PARITY)
                    begin
                        op_pop = !op.last;
                    end
                    else
                    begin
                        op_pop = !op.parity && !op.last;
                    end
                end
            end
            B_FLUSH:
            begin
                if (flush_go)
                begin
                    emit            = 1'b1;
                    beat.out_byte   = accum_reg[7:0] & flush_mask;
                    beat.out_bits   = flush_bits;
                    beat.frame_end  = flush_end;
                    beat.total_bits = flush_end ? op.total : '0;
                    beat.overflow   = flush_end && op.overflow;
                    if (flush_end)
                    begin
                        accum_next = '0;
                        count_next = '0;
                        op_pop     = 1'b1;
                    end
                    else
                    begin
                        accum_next = shifted;
                        count_next = count_reg - BYTE_BITS;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = beat;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_DATA;
            accum_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            accum_reg     <= accum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

@@ hdl/iso14443a_frame_builder.sv @@
// throughput: one payload byte per cycle without parity while the output is not stalled;
// with parity the packer appends byte and parity bit in separate steps and takes the next
// byte only after the parity bit; a frame end with crc holds the input while the front queues the crc bytes
// reset: asynchronous, clears the frame state, the op queue and the output valid
// top level: front end, op queue and bit packer; depends on isofb_pkg
module iso14443a_frame_builder import isofb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  req_t req_data,
    input  logic req_valid,
    output logic req_stall,
    output rsp_t rsp_data,
    output logic rsp_valid,
    input  logic rsp_stall
);

    op_t       push_op, head_op;
    logic      op_push, op_pop;
    q_status_t q_status;

    isofb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (push_op),
        .op_push   (op_push),
        .q_status  (q_status)
    );

    isofb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (op_push),
        .wr_op  (push_op),
        .rd     (op_pop),
        .rd_op  (head_op),
        .status (q_status)
    );

    isofb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (head_op),
        .q_status  (q_status),
        .op_pop    (op_pop),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule

@@ hdl/isofb_checker.sv @@
// port level checks for the frame builder, bound to the top level
// depends on isofb_pkg and iso14443a_frame_builder
module isofb_checker import isofb_pkg::*; (
    input logic clk,
    input logic rst_n,
    input req_t req_data,
    input logic req_valid,
    input logic req_stall,
    input rsp_t rsp_data,
    input logic rsp_valid,
    input logic rsp_stall
);

    // a stalled beat stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled beat changed");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.out_bits != 4'd0 && rsp_data.out_bits <= BYTE_BITS)
        else $error("out_bits out of range");

    // only the closing beat may be partial or carry frame totals
    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.frame_end |->
            rsp_data.out_bits == BYTE_BITS && rsp_data.total_bits == '0 && !rsp_data.overflow)
        else $error("mid-frame beat not a full plain byte");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.out_byte >> rsp_data.out_bits) == 8'h00)
        else $error("padding bits not zero");

endmodule

bind iso14443a_frame_builder isofb_checker u_isofb_checker (.*);

@@ tb/sv/tb_top.sv @@
// self-checking testbench for iso14443a_frame_builder: crc_a and odd parity framing
// drives frames through a valid/stall driver and checks each beat against a bit-level predictor
// depends on isofb_pkg and the iso14443a_frame_builder rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import isofb_pkg::*;

    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
    localparam int GAP_MAX      = 6;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AT_BEAT = 20;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_BEATS = 20;

    typedef struct {
        req_t beat;
        bit   wait_drain;
    } pend_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    req_t req_data = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    rsp_t rsp_data;
    logic rsp_valid;
    logic rsp_stall = 1'b0;

    pend_t pending_beats[$];
    rsp_t  frame_results[$];

    int error_count = 0;
    int got_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int send_items = 0;
    int recv_items = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int idle_cycles = 0;

    // predictor state
    logic [15:0] crc_run = CRC_PRESET;
    logic [15:0] acc_bits = '0;
    logic [3:0]  acc_n = '0;
    logic [8:0]  byte_cnt = '0;
    logic        crc_on = 1'b0;
    logic        par_on = 1'b0;
    logic        open_frame = 1'b0;
    logic        dropped = 1'b0;

    iso14443a_frame_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // reflected crc-16, one bit at a time
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ data[i])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic int draw_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    task automatic push_result(input logic [7:0] b, input logic [3:0] n);
        rsp_t r;
        r = '0;
        r.out_byte = b;
        r.out_bits = n;
        frame_results.push_back(r);
    endtask

    task automatic push_bits(input logic [15:0] bits, input logic [3:0] k);
        if (acc_n >= 4'd8)
        begin
            push_result(acc_bits[7:0], 4'd8);
            acc_bits = acc_bits >> 8;
            acc_n = acc_n - 4'd8;
        end
        acc_bits = acc_bits | (bits << acc_n);
        acc_n = acc_n + k;
    endtask

    task automatic pack_byte(input logic [7:0] b);
        push_bits({8'h00, b}, 4'd8);
        if (par_on)
            push_bits({15'd0, ~^b}, 4'd1);
        byte_cnt = byte_cnt + 9'd1;
    endtask

    // expected beats caused by one accepted input beat
    task automatic frame_pack_step(input req_t b);
        int cap;
        int n_before;
        logic [15:0] crc_word;
        rsp_t tail;
        n_before = frame_results.size();
        if (!open_frame)
        begin
            crc_on = b.crc_en;
            par_on = b.par_en;
            crc_run = CRC_PRESET;
            acc_bits = '0;
            acc_n = '0;
            byte_cnt = '0;
            dropped = 1'b0;
            open_frame = 1'b1;
        end
        cap = crc_on ? MAX_FRAME - 2 : MAX_FRAME;
        if (int'(byte_cnt) < cap)
        begin
            crc_run = crc_shift_byte(crc_run, b.data_byte);
            pack_byte(b.data_byte);
        end
        else
            dropped = 1'b1;
        if (b.last_byte)
        begin
            crc_word = crc_run;
            if (crc_on)
            begin
                pack_byte(crc_word[7:0]);
                pack_byte(crc_word[15:8]);
            end
            while (acc_n >= 4'd8)
            begin
                push_result(acc_bits[7:0], 4'd8);
                acc_bits = acc_bits >> 8;
                acc_n = acc_n - 4'd8;
            end
            if (acc_n > 4'd0)
                push_result(acc_bits[7:0] & ~(8'hFF << acc_n), acc_n);
            acc_bits = '0;
            acc_n = '0;
            if (frame_results.size() > n_before)
            begin
                tail = frame_results.pop_back();
                tail.frame_end = 1'b1;
                tail.total_bits = TOTAL_W'(int'(byte_cnt) * (par_on ? 9 : 8));
                tail.overflow = dropped;
                frame_results.push_back(tail);
            end
            open_frame = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        error_count++;
        $display("mismatch at beat %0d: %s = %0d, expected %0d", got_count, what, got_v, want_v);
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (frame_results.size() == 0)
            report_mismatch("beat with no prediction, out_byte", got.out_byte, 0);
        else
        begin
            want = frame_results.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.out_bits !== want.out_bits)
                report_mismatch("out_bits", got.out_bits, want.out_bits);
            if (got.frame_end !== want.frame_end)
                report_mismatch("frame_end", got.frame_end, want.frame_end);
            if (got.total_bits !== want.total_bits)
                report_mismatch("total_bits", got.total_bits, want.total_bits);
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", got.overflow, want.overflow);
        end
    endtask

    task automatic queue_beat(input logic [7:0] d, input bit crc, input bit par, input bit last,
                              input bit pause);
        pend_t p;
        p.beat.data_byte = d;
        p.beat.crc_en = crc;
        p.beat.par_en = par;
        p.beat.last_byte = last;
        p.wait_drain = pause;
        pending_beats.push_back(p);
    endtask

    // flags on beats after the first are random noise, the block must ignore them
    task automatic queue_frame(input int len, input bit crc, input bit par, input bit pause);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                queue_beat(8'($urandom), crc, par, len == 1, pause);
            else
                queue_beat(8'($urandom), 1'($urandom), 1'($urandom), i == len - 1, 1'b0);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic offer;
        pend_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
        end
        else
        begin
            offer = req_valid;
            if (req_valid && !req_stall)
            begin
                frame_pack_step(req_data);
                offer = 1'b0;
                send_items++;
                if (send_items % 25 == 0)
                    send_calm = ($urandom_range(0, 3) == 0);
                send_gap = draw_gap(send_calm);
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].wait_drain && frame_results.size() > 0))
                begin
                    nxt = pending_beats.pop_front();
                    req_data <= nxt.beat;
                    offer = 1'b1;
                end
            end
            req_valid <= offer;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin : recv_proc
        logic hold;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got_count++;
                check_result(rsp_data);
                recv_items++;
                if (recv_items % 30 == 0)
                    recv_calm = ($urandom_range(0, 3) == 0);
                recv_gap = draw_gap(recv_calm);
                // long hold-off so the block backs up and stalls its input
                if (got_count == HOLD_AT_BEAT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                hold = 1'b1;
            end
            else
                hold = 1'b0;
            rsp_stall <= hold;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int len;
        int r;
        // short frames: byte extremes, every flag combination, ignored late flags
        queue_beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_beat(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_beat(8'h12, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h34, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h56, 1'b1, 1'b1, 1'b1, 1'b0);
        queue_beat(8'h01, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_beat(8'h55, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_beat(8'hAA, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_beat(8'h26, 1'b1, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
            queue_beat(8'($urandom), 1'b0, 1'b1, i == 7, 1'b0);
        queue_beat(8'h93, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_beat(8'h70, 1'b1, 1'b1, 1'b1, 1'b0);

        // one byte over the limit with crc and parity: the last byte is dropped
        queue_frame(MAX_FRAME - 1, 1'b1, 1'b1, 1'b1);

        n = 0;
        while (n < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                len = $urandom_range(1, 8);
            else if (r < 9)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(25, 60);
            queue_frame(len, 1'($urandom), 1'($urandom), n == 0 || $urandom_range(0, 7) == 0);
            n += len;
        end

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pending_beats.size() != 0 || req_valid)
            @(posedge clk);
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/isofb_pkg.sv
hdl/isofb_queue.sv
hdl/isofb_front.sv
hdl/isofb_back.sv
hdl/iso14443a_frame_builder.sv
hdl/isofb_checker.sv
tb/sv/tb_top.sv
